// ===== design/kdt_pkg.sv =====
// ----------------------------------------------------------------------------
// kdt_pkg
// Shared types and codes for the keyed device table: request kinds, result
// codes, the stored record layout and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package kdt_pkg;

    // request kinds
    localparam logic [1:0] REQ_UPSERT  = 2'd0;
    localparam logic [1:0] REQ_SEARCH  = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_CLEAR   = 2'd3;

    // result codes
    localparam logic [1:0] RES_OK         = 2'd0;
    localparam logic [1:0] RES_FULL       = 2'd1;
    localparam logic [1:0] RES_NOT_FOUND  = 2'd2;
    localparam logic [1:0] RES_NOT_IN_USE = 2'd3;

    // one stored device record
    typedef struct packed {
        logic [7:0]  dev_type;
        logic [7:0]  dev_variant;
        logic [47:0] mac;
        logic [7:0]  major;
        logic [7:0]  minor;
        logic [7:0]  revision;
        logic [7:0]  status;
        logic [7:0]  mask;
    } rec_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic rel_rd;
        logic commit;
    } kdt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       scan_done;
        logic       out_free;
    } kdt_status_t;

endpackage

// ===== design/kdt_if.sv =====
// ----------------------------------------------------------------------------
// kdt_if
// Valid/ready channels of the keyed device table: request in, result out.
// ----------------------------------------------------------------------------
interface kdt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  dev_type;
    logic [7:0]  dev_variant;
    logic [47:0] mac_addr;
    logic [7:0]  ver_major;
    logic [7:0]  ver_minor;
    logic [7:0]  ver_revision;
    logic [7:0]  dev_status;
    logic [7:0]  image_mask;
    logic [3:0]  slot_sel;

    modport source (
        output valid, req_type, dev_type, dev_variant, mac_addr, ver_major,
               ver_minor, ver_revision, dev_status, image_mask, slot_sel,
        input  ready
    );
    modport sink (
        input  valid, req_type, dev_type, dev_variant, mac_addr, ver_major,
               ver_minor, ver_revision, dev_status, image_mask, slot_sel,
        output ready
    );
endinterface

interface kdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_code;
    logic [3:0]  slot_out;
    logic [7:0]  rec_type;
    logic [7:0]  rec_variant;
    logic [47:0] rec_mac;
    logic [7:0]  rec_major;
    logic [7:0]  rec_minor;
    logic [7:0]  rec_revision;
    logic [7:0]  rec_status;
    logic [7:0]  rec_mask;

    modport source (
        output valid, result_code, slot_out, rec_type, rec_variant, rec_mac,
               rec_major, rec_minor, rec_revision, rec_status, rec_mask,
        input  ready
    );
    modport sink (
        input  valid, result_code, slot_out, rec_type, rec_variant, rec_mac,
               rec_major, rec_minor, rec_revision, rec_status, rec_mask,
        output ready
    );
endinterface

// ===== design/kdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kdt_ctrl
// Request sequencer: accept, dispatch by kind, scan or read as the kind needs, then commit.
// ----------------------------------------------------------------------------
module kdt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                ready,
    input  kdt_pkg::kdt_status_t status,
    output kdt_pkg::kdt_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_REL      = 3'd3;
    localparam logic [2:0] S_COMMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    kdt_pkg::REQ_UPSERT:  state_next = S_SCAN;
                    kdt_pkg::REQ_SEARCH:  state_next = S_SCAN;
                    kdt_pkg::REQ_RELEASE: state_next = S_REL;
                    default:              state_next = S_COMMIT;
                endcase
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_REL:
            begin
                cmd.rel_rd = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // wait for room in the result register
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ready = (state_reg == S_IDLE);

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.rel_rd, cmd.commit}))
        else $error("more than one datapath command at once");

endmodule

// ===== design/kdt_dpath.sv =====
// ----------------------------------------------------------------------------
// kdt_dpath
// Record memory, slot valid bits, scan pipeline and result register.
// ----------------------------------------------------------------------------
module kdt_dpath #(
    parameter int ENTRIES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    kdt_req_if.sink              req,
    kdt_rsp_if.source            rsp,
    input  kdt_pkg::kdt_cmd_t    cmd,
    output kdt_pkg::kdt_status_t status
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    // latched request
    logic [1:0]       kind_reg;
    kdt_pkg::rec_t    new_rec_reg;
    logic [3:0]       sel_reg;

    // slot valid bits
    logic [ENTRIES-1:0] valid_reg;

    // record memory with registered read
    kdt_pkg::rec_t    rec_mem [ENTRIES];
    kdt_pkg::rec_t    rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_live_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;

    // scan address generator
    logic [IDX_W-1:0] addr_reg;
    logic             addr_done_reg;

    // scan outcome
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    kdt_pkg::rec_t    hit_rec_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // result register
    logic             out_valid_reg;
    logic [1:0]       out_code_reg;
    logic [3:0]       out_slot_reg;
    kdt_pkg::rec_t    out_rec_reg;

    logic             cur_valid;
    logic             key_hit;
    logic             mac_hit;
    logic             hit;
    logic             free;
    logic             out_free;

    logic [IDX_W-1:0] sel_idx;
    logic             sel_live;
    logic [IDX_W-1:0] wr_idx;
    logic             mem_we;
    logic             set_en;
    logic             rel_en;
    logic             clr_all;
    logic [1:0]       res_code;
    logic [3:0]       res_slot;
    kdt_pkg::rec_t    res_rec;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg             <= req.req_type;
            new_rec_reg.dev_type    <= req.dev_type;
            new_rec_reg.dev_variant <= req.dev_variant;
            new_rec_reg.mac         <= req.mac_addr;
            new_rec_reg.major       <= req.ver_major;
            new_rec_reg.minor       <= req.ver_minor;
            new_rec_reg.revision    <= req.ver_revision;
            new_rec_reg.status      <= req.dev_status;
            new_rec_reg.mask        <= req.image_mask;
            sel_reg              <= req.slot_sel;
        end
    end

    // memory port
    assign rd_en   = cmd.rel_rd || (cmd.scan && !addr_done_reg);
    assign rd_addr = cmd.rel_rd ? sel_idx : addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[wr_idx] <= new_rec_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= rec_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            addr_done_reg <= 1'b0;
            rd_idx_reg    <= '0;
            rd_live_reg   <= 1'b0;
        end
        else
        begin
            rd_live_reg <= cmd.scan && !addr_done_reg;
            if (rd_en)
            begin
                rd_idx_reg <= rd_addr;
            end
            if (cmd.load)
            begin
                addr_reg      <= '0;
                addr_done_reg <= 1'b0;
            end
            else if (cmd.scan && !addr_done_reg)
            begin
                if (addr_reg == LAST)
                begin
                    addr_done_reg <= 1'b1;
                end
                else
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end
        end
    end

    // compare stage on the registered read
    assign cur_valid = valid_reg[rd_idx_reg];
    assign key_hit   = (rd_data_reg.dev_type == new_rec_reg.dev_type) &&
                       (rd_data_reg.dev_variant == new_rec_reg.dev_variant);
    assign mac_hit   = (rd_data_reg.mac == new_rec_reg.mac);
    assign hit       = rd_live_reg && cur_valid &&
                       ((kind_reg == kdt_pkg::REQ_UPSERT) ? key_hit : mac_hit);
    assign free      = rd_live_reg && !cur_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (hit && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
            end
            if (free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && hit && !hit_found_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_rec_reg <= rd_data_reg;
        end
        if (cmd.scan && free && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // commit decision
    assign sel_idx  = IDX_W'(sel_reg);
    assign sel_live = (32'(sel_reg) < ENTRIES) && valid_reg[sel_idx];

    always_comb
    begin
        res_code = kdt_pkg::RES_OK;
        res_slot = '0;
        res_rec  = '0;
        wr_idx   = hit_found_reg ? hit_idx_reg : free_idx_reg;
        mem_we   = 1'b0;
        set_en   = 1'b0;
        rel_en   = 1'b0;
        clr_all  = 1'b0;
        case (kind_reg)
            kdt_pkg::REQ_UPSERT:
            begin
                if (hit_found_reg || free_found_reg)
                begin
                    res_slot = 4'(wr_idx);
                    res_rec  = new_rec_reg;
                    mem_we   = cmd.commit;
                    set_en   = cmd.commit;
                end
                else
                begin
                    res_code = kdt_pkg::RES_FULL;
                end
            end
            kdt_pkg::REQ_SEARCH:
            begin
                if (hit_found_reg)
                begin
                    res_slot = 4'(hit_idx_reg);
                    res_rec  = hit_rec_reg;
                end
                else
                begin
                    res_code = kdt_pkg::RES_NOT_FOUND;
                end
            end
            kdt_pkg::REQ_RELEASE:
            begin
                res_slot = sel_reg;
                if (sel_live)
                begin
                    res_rec = rd_data_reg;
                    rel_en  = cmd.commit;
                end
                else
                begin
                    res_code = kdt_pkg::RES_NOT_IN_USE;
                end
            end
            default:
            begin
                clr_all = cmd.commit;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr_all)
        begin
            valid_reg <= '0;
        end
        else if (set_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
        else if (rel_en)
        begin
            valid_reg[sel_idx] <= 1'b0;
        end
    end

    // result register
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_code_reg <= res_code;
            out_slot_reg <= res_slot;
            out_rec_reg  <= res_rec;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_code  = out_code_reg;
    assign rsp.slot_out     = out_slot_reg;
    assign rsp.rec_type     = out_rec_reg.dev_type;
    assign rsp.rec_variant  = out_rec_reg.dev_variant;
    assign rsp.rec_mac      = out_rec_reg.mac;
    assign rsp.rec_major    = out_rec_reg.major;
    assign rsp.rec_minor    = out_rec_reg.minor;
    assign rsp.rec_revision = out_rec_reg.revision;
    assign rsp.rec_status   = out_rec_reg.status;
    assign rsp.rec_mask     = out_rec_reg.mask;

    assign status.kind      = kind_reg;
    assign status.scan_done = rd_live_reg && (hit || (rd_idx_reg == LAST));
    assign status.out_free  = out_free;

    a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not load the result register");

    a_free_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && free_found_reg) |-> !valid_reg[free_idx_reg])
        else $error("recorded free slot is in use");

    a_hit_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && hit_found_reg) |-> valid_reg[hit_idx_reg])
        else $error("recorded hit slot is not valid");

endmodule

// ===== design/keyed_device_table.sv =====
// ----------------------------------------------------------------------------
// keyed_device_table
// Table of device records keyed by type and variant, with upsert, search by
// MAC, release of one slot and clear of the whole table.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  --------+-----+--------------+----------------------------------------------
//  req     | in  | valid/ready  | req_type, key, MAC, versions, status, slot
//  rsp     | out | valid/ready  | result_code, slot_out, stored record fields
//
//  one request at a time; upsert and search scan the record memory one slot
//  per cycle through its single read port, up to the first hit or the last
//  slot; release reads its one slot, clear goes straight to the commit
//  the result register lets the next request in while a result waits
//  a stalled result holds the commit of the following request
//  rst_n clears the slot valid bits at once; record contents need no reset
// ----------------------------------------------------------------------------
module keyed_device_table #(
    parameter int ENTRIES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    kdt_req_if.sink    req,
    kdt_rsp_if.source  rsp
);

    kdt_pkg::kdt_cmd_t    cmd;
    kdt_pkg::kdt_status_t status;
    logic                 ready;

    // sequencer: owns the request handshake and steps the datapath
    kdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .ready     (ready),
        .status    (status),
        .cmd       (cmd)
    );

    assign req.ready = ready;

    // datapath: record memory, valid bits, scan and result register
    kdt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule

// ===== dv/keyed_device_table_test.sv =====
// ----------------------------------------------------------------------------
// keyed_device_table_test
// Self-checking bench for the keyed device table. A directed opening covers
// the empty, full and cleared table, key updates, MAC lookups and slot
// releases, then random traffic drawn from small key and MAC pools keeps the
// table busy. A scoreboard holds its own copy of the table, predicts one
// result per accepted request and checks results in order, field by field.
// ----------------------------------------------------------------------------

// one request as the bench sees it, field order matches the request channel
typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  dev_type;
    logic [7:0]  dev_variant;
    logic [47:0] mac;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [7:0]  revision;
    logic [7:0]  status;
    logic [7:0]  mask;
    logic [3:0]  slot;
} table_req_t;

typedef struct packed {
    logic [1:0]    code;
    logic [3:0]    slot;
    kdt_pkg::rec_t rec;
} table_rsp_t;

class device_table_scoreboard;
    localparam int SLOTS = 16;

    bit            slot_used [SLOTS];
    kdt_pkg::rec_t records [SLOTS];
    table_rsp_t    pending_results [$];
    int            mismatches;

    function new();
        mismatches = 0;
        foreach (slot_used[i])
        begin
            slot_used[i] = 1'b0;
            records[i]   = '0;
        end
    endfunction

    // update the table copy and queue the result this request must produce
    function void log_request(table_req_t r);
        table_rsp_t want;
        int         hit;
        want = '0;
        hit  = -1;
        case (r.kind)
            kdt_pkg::REQ_UPSERT:
            begin
                for (int i = 0; i < SLOTS && hit < 0; i++)
                    if (slot_used[i] && records[i].dev_type == r.dev_type
                            && records[i].dev_variant == r.dev_variant)
                        hit = i;
                for (int i = 0; i < SLOTS && hit < 0; i++)
                    if (!slot_used[i])
                        hit = i;
                if (hit < 0)
                    want.code = kdt_pkg::RES_FULL;
                else
                begin
                    slot_used[hit] = 1'b1;
                    records[hit]   = {r.dev_type, r.dev_variant, r.mac, r.major,
                                      r.minor, r.revision, r.status, r.mask};
                    want.code = kdt_pkg::RES_OK;
                    want.slot = hit[3:0];
                    want.rec  = records[hit];
                end
            end
            kdt_pkg::REQ_SEARCH:
            begin
                for (int i = 0; i < SLOTS && hit < 0; i++)
                    if (slot_used[i] && records[i].mac == r.mac)
                        hit = i;
                if (hit < 0)
                    want.code = kdt_pkg::RES_NOT_FOUND;
                else
                begin
                    want.code = kdt_pkg::RES_OK;
                    want.slot = hit[3:0];
                    want.rec  = records[hit];
                end
            end
            kdt_pkg::REQ_RELEASE:
            begin
                want.slot = r.slot;
                if (slot_used[r.slot])
                begin
                    want.code          = kdt_pkg::RES_OK;
                    want.rec           = records[r.slot];
                    slot_used[r.slot]  = 1'b0;
                end
                else
                    want.code = kdt_pkg::RES_NOT_IN_USE;
            end
            default:
            begin
                // stores keep their contents, only the valid bits go
                foreach (slot_used[i])
                    slot_used[i] = 1'b0;
                want.code = kdt_pkg::RES_OK;
            end
        endcase
        pending_results.push_back(want);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [47:0] got, logic [47:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_result(table_rsp_t got);
        table_rsp_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with no request outstanding");
            return;
        end
        want = pending_results.pop_front();
        compare_field("result_code", 48'(got.code), 48'(want.code));
        compare_field("slot_out", 48'(got.slot), 48'(want.slot));
        compare_field("rec_type", 48'(got.rec.dev_type), 48'(want.rec.dev_type));
        compare_field("rec_variant", 48'(got.rec.dev_variant),
                      48'(want.rec.dev_variant));
        compare_field("rec_mac", got.rec.mac, want.rec.mac);
        compare_field("rec_major", 48'(got.rec.major), 48'(want.rec.major));
        compare_field("rec_minor", 48'(got.rec.minor), 48'(want.rec.minor));
        compare_field("rec_revision", 48'(got.rec.revision), 48'(want.rec.revision));
        compare_field("rec_status", 48'(got.rec.status), 48'(want.rec.status));
        compare_field("rec_mask", 48'(got.rec.mask), 48'(want.rec.mask));
    endtask
endclass

module keyed_device_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS = 1400;
    localparam int KEY_POOL    = 24;    // more keys than slots, so the table fills
    localparam int MAC_POOL    = 32;
    localparam int SETTLE      = 40;    // cycles after the last result

    logic clk;
    logic rst_n;
    logic quiet_phase;                  // both sides run without idling

    logic [15:0] key_pool [KEY_POOL];
    logic [47:0] mac_pool [MAC_POOL];

    device_table_scoreboard sb;

    kdt_req_if req_ch ();
    kdt_rsp_if rsp_ch ();

    keyed_device_table #(
        .ENTRIES(16)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #10 clk = ~clk;

    // 48 random bits
    function automatic logic [47:0] random_mac();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[47:0];
    endfunction

    function automatic table_req_t make_req(logic [1:0] kind, logic [15:0] key,
                                            logic [47:0] mac, logic [39:0] info,
                                            logic [3:0] slot);
        return {kind, key, mac, info, slot};
    endfunction

    // random request: mostly pooled keys and MACs so that updates, hits and
    // a full table all occur; every field keeps fully random bits otherwise
    function automatic table_req_t random_request();
        logic [127:0] wide;
        table_req_t   r;
        int           pick;
        wide = {$urandom, $urandom, $urandom, $urandom};
        r    = wide[$bits(table_req_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            r.kind = kdt_pkg::REQ_UPSERT;
            if ($urandom_range(0, 99) < 85)
                {r.dev_type, r.dev_variant} = key_pool[$urandom_range(0, KEY_POOL - 1)];
            if ($urandom_range(0, 99) < 80)
                r.mac = mac_pool[$urandom_range(0, MAC_POOL - 1)];
        end
        else if (pick < 75)
        begin
            r.kind = kdt_pkg::REQ_SEARCH;
            if ($urandom_range(0, 99) < 70)
                r.mac = mac_pool[$urandom_range(0, MAC_POOL - 1)];
        end
        else if (pick < 95)
            r.kind = kdt_pkg::REQ_RELEASE;
        else
            r.kind = kdt_pkg::REQ_CLEAR;
        return r;
    endfunction

    task automatic put_fields(table_req_t r);
        req_ch.req_type     = r.kind;
        req_ch.dev_type     = r.dev_type;
        req_ch.dev_variant  = r.dev_variant;
        req_ch.mac_addr     = r.mac;
        req_ch.ver_major    = r.major;
        req_ch.ver_minor    = r.minor;
        req_ch.ver_revision = r.revision;
        req_ch.dev_status   = r.status;
        req_ch.image_mask   = r.mask;
        req_ch.slot_sel     = r.slot;
    endtask

    // called at a falling edge, returns at the falling edge after the accept;
    // valid stays high across back-to-back requests
    task automatic send_request(table_req_t r);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        put_fields(r);
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.log_request(r);
        @(negedge clk);
    endtask

    // hold the request side low until every result is back
    task automatic wait_for_drain();
        req_ch.valid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
    endtask

    // result side: random stalls, sample on the rising edge
    initial
    begin
        table_rsp_t got;
        int         stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            got.code = rsp_ch.result_code;
            got.slot = rsp_ch.slot_out;
            got.rec  = {rsp_ch.rec_type, rsp_ch.rec_variant, rsp_ch.rec_mac,
                        rsp_ch.rec_major, rsp_ch.rec_minor, rsp_ch.rec_revision,
                        rsp_ch.rec_status, rsp_ch.rec_mask};
            sb.check_result(got);
            @(negedge clk);
        end
    end

    // main sequence
    initial
    begin
        logic [47:0] bits48;
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        quiet_phase = 1'b0;
        req_ch.valid = 1'b0;
        put_fields('0);
        foreach (key_pool[i])
            key_pool[i] = 16'($urandom_range(0, 65535));
        foreach (mac_pool[i])
            mac_pool[i] = random_mac();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table: lookup misses, release of a free slot
        send_request(make_req(kdt_pkg::REQ_SEARCH, 16'h0000, 48'h0, 40'h0, 4'h0));
        send_request(make_req(kdt_pkg::REQ_RELEASE, 16'h0000, 48'h0, 40'h0, 4'h0));

        // extreme keys and data, then an update of the all-ones key
        send_request(make_req(kdt_pkg::REQ_UPSERT, 16'h0000, 48'h0, 40'h0, 4'h0));
        send_request(make_req(kdt_pkg::REQ_UPSERT, 16'hffff, '1, '1, 4'hf));
        send_request(make_req(kdt_pkg::REQ_UPSERT, 16'hffff, 48'h0123_4567_89ab,
                              40'h12_34_56_78_9a, 4'h5));

        // lookup hit, and a miss on the MAC that the update replaced
        send_request(make_req(kdt_pkg::REQ_SEARCH, '1, 48'h0, '1, '1));
        send_request(make_req(kdt_pkg::REQ_SEARCH, 16'h0000, '1, 40'h0, 4'h0));

        // release a live slot, then the same slot again, then a never-used one
        send_request(make_req(kdt_pkg::REQ_RELEASE, 16'h0000, 48'h0, 40'h0, 4'h0));
        send_request(make_req(kdt_pkg::REQ_RELEASE, '1, '1, '1, 4'h0));
        send_request(make_req(kdt_pkg::REQ_RELEASE, 16'h0000, 48'h0, 40'h0, 4'hf));

        // fill every free slot with fresh keys
        for (int k = 0; k < 15; k++)
        begin
            bits48 = random_mac();
            send_request(make_req(kdt_pkg::REQ_UPSERT, {8'h10 + k[7:0], k[7:0]},
                                  random_mac(), bits48[39:0], bits48[43:40]));
        end

        // full table: new key refused, existing key still updated
        send_request(make_req(kdt_pkg::REQ_UPSERT, 16'h5a5a, random_mac(), 40'h0, 4'h0));
        send_request(make_req(kdt_pkg::REQ_UPSERT, 16'hffff, 48'hfedc_ba98_7654,
                              40'ha5_5a_c3_3c_81, 4'h0));
        send_request(make_req(kdt_pkg::REQ_RELEASE, 16'h0000, 48'h0, 40'h0, 4'hf));

        // clear, then a stale MAC must not be found
        send_request(make_req(kdt_pkg::REQ_CLEAR, 16'h0000, 48'h0, 40'h0, 4'h0));
        send_request(make_req(kdt_pkg::REQ_SEARCH, 16'h0000, 48'hfedc_ba98_7654,
                              40'h0, 4'h0));

        // random traffic, with stretches of no idling and drain pauses
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            quiet_phase = ((i / 200) % 3 == 2);
            if (i % 350 == 175)
                wait_for_drain();
            send_request(random_request());
        end

        wait_for_drain();
        repeat (SETTLE) @(negedge clk);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
